### rtl/urgl_pkg.sv
package urgl_pkg;

    // Tick timing
    localparam int TICKS_PER_MS    = 1000;
    localparam int TRIG_LOW_TICKS  = 2;
    localparam int TRIG_HIGH_TICKS = 10;

    // Field widths
    localparam int TICK_W  = 16;
    localparam int PRE_W   = 10;
    localparam int MS_W    = 16;
    localparam int DIST_W  = 15;
    localparam int THR_W   = 13;
    localparam int HYS_W   = 10;
    localparam int CFG_W   = 16;
    localparam int CFGIX_W = 2;

    // Reset values of the registers
    localparam logic [THR_W-1:0]  THRESHOLD_RST  = 13'd160;
    localparam logic [HYS_W-1:0]  HYSTERESIS_RST = 10'd48;
    localparam logic [MS_W-1:0]   COOLDOWN_RST   = 16'd500;
    localparam logic [TICK_W-1:0] TIMEOUT_RST    = 16'd30000;
    localparam logic [DIST_W-1:0] DIST_ERR       = 15'd16;

    // Distance scaling: q4 = floor((us*343 + 625) / 1250)
    // Division done as multiply by ceil(2^36/1250), exact for a 25-bit numerator.
    localparam int                 SCALE_W     = 25;
    localparam int                 RECIP_W     = 26;
    localparam int                 PROD_W      = SCALE_W + RECIP_W;
    localparam int                 RECIP_SHIFT = 36;
    localparam logic [SCALE_W-1:0] SCALE_MUL   = 25'd343;
    localparam logic [SCALE_W-1:0] SCALE_ADD   = 25'd625;
    localparam logic [RECIP_W-1:0] RECIP       = 26'd54975582;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TLOW,
        PH_THIGH,
        PH_WAIT,
        PH_MEAS
    } t_phase;

    typedef enum logic [CFGIX_W-1:0] {
        CFG_THRESHOLD,
        CFG_HYSTERESIS,
        CFG_COOLDOWN,
        CFG_TIMEOUT
    } t_cfg_idx;

    // Per-tick flags carried down the pipeline
    typedef struct packed {
        logic trig;
        logic busy;
        logic done;
        logic error;
        logic succ;   // measurement finished with a valid echo width
        logic wrap;   // millisecond boundary in this tick
    } t_flags;

endpackage

### rtl/ultrasonic_ranger_gesture_latch_core.sv
// Ultrasonic ranger with latched gesture detector. Every input transfer is one
// microsecond tick (start command and sampled echo level) and yields exactly one
// result transfer. The block takes one tick per clock cycle; each tick passes in turn
// through the control stage, two multiply stages for the echo-to-distance scaling
// and the gesture and result register, and the whole pipeline holds while the
// result is not taken. Configuration writes are always accepted and should only be
// made while no ticks are in flight.
module ultrasonic_ranger_gesture_latch_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Tick input
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [7:0]                   i_s_tdata,   // [0] cmd, [1] echo
    // Result output
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [23:0]                  o_m_tdata,   // [0] trig, [1] busy_res,
                                                      // [2] done_res, [3] error,
                                                      // [18:4] distance_q4, [19] gesture
    // Register writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [urgl_pkg::CFGIX_W-1:0] i_cfg_index,
    input  logic [urgl_pkg::CFG_W-1:0]   i_cfg_data
);
    import urgl_pkg::*;

    logic              w_adv;
    logic              w_accept;

    logic [THR_W-1:0]  r_threshold;
    logic [HYS_W-1:0]  r_hysteresis;
    logic [MS_W-1:0]   r_cooldown;
    logic [TICK_W-1:0] r_timeout;

    logic              w_v1, w_v3, w_vo;
    t_flags            w_f1, w_f3, w_fo;
    logic [TICK_W-1:0] w_ticks;
    logic [DIST_W-1:0] w_dist3, w_disto;
    logic              w_gest;

    // Whole pipeline moves when the result register is free or being drained
    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;
    assign w_accept   = i_s_tvalid && w_adv;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RST;
            r_hysteresis <= HYSTERESIS_RST;
            r_cooldown   <= COOLDOWN_RST;
            r_timeout    <= TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_THRESHOLD:  r_threshold  <= i_cfg_data[THR_W-1:0];
                CFG_HYSTERESIS: r_hysteresis <= i_cfg_data[HYS_W-1:0];
                CFG_COOLDOWN:   r_cooldown   <= i_cfg_data[MS_W-1:0];
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data[TICK_W-1:0];
                default:        r_timeout    <= r_timeout;
            endcase
        end
    end

    urgl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_accept  (w_accept),
        .i_cmd     (i_s_tdata[0]),
        .i_echo    (i_s_tdata[1]),
        .i_timeout (r_timeout),
        .o_valid   (w_v1),
        .o_flags   (w_f1),
        .o_ticks   (w_ticks)
    );

    urgl_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_v1),
        .i_flags (w_f1),
        .i_ticks (w_ticks),
        .o_valid (w_v3),
        .o_flags (w_f3),
        .o_dist  (w_dist3)
    );

    urgl_judge u_judge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_valid      (w_v3),
        .i_flags      (w_f3),
        .i_dist       (w_dist3),
        .i_threshold  (r_threshold),
        .i_hysteresis (r_hysteresis),
        .i_cooldown   (r_cooldown),
        .o_valid      (w_vo),
        .o_flags      (w_fo),
        .o_dist       (w_disto),
        .o_gesture    (w_gest)
    );

    // Result packing
    assign o_m_tvalid = w_vo;
    assign o_m_tdata  = {4'd0, w_gest, w_disto, w_fo.error, w_fo.done, w_fo.busy, w_fo.trig};

`ifndef ASSERT_OFF
    // A gesture is only reported with a successful completion
    a_gest_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[19] |-> o_m_tdata[2] && !o_m_tdata[3])
        else $error("gesture without successful completion");

    // The completion tick leaves the ranger idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2] |-> !o_m_tdata[1])
        else $error("done while still busy");

    // A timed-out measurement reports one centimetre
    a_err_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2] && o_m_tdata[3] |-> w_disto == DIST_ERR)
        else $error("error completion with wrong distance");

    // Pipeline holds while the result is stalled
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> w_v3 == $past(w_v3) && w_v1 == $past(w_v1))
        else $error("pipeline moved during stall");
`endif

endmodule

### rtl/urgl_ctrl.sv
module urgl_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_accept,
    input  logic                        i_cmd,
    input  logic                        i_echo,
    input  logic [urgl_pkg::TICK_W-1:0] i_timeout,
    output logic                        o_valid,
    output urgl_pkg::t_flags            o_flags,
    output logic [urgl_pkg::TICK_W-1:0] o_ticks
);
    import urgl_pkg::*;

    t_phase              r_phase, n_phase, w_eff_phase;
    logic [TICK_W-1:0]   r_ticks, n_ticks, w_eff_ticks;
    logic                r_err, n_err, w_eff_err;
    logic [PRE_W-1:0]    r_pre, n_pre;
    logic                w_wrap;
    logic                w_done;
    logic                w_to_err;

    logic                r_valid;
    t_flags              r_flags;
    logic [TICK_W-1:0]   r_out_ticks;

    // Millisecond prescaler
    always_comb begin
        w_wrap = (r_pre == PRE_W'(TICKS_PER_MS - 1));
        n_pre  = w_wrap ? '0 : r_pre + PRE_W'(1);
    end

    // Next state: start from idle, then per-phase sequencing
    always_comb begin
        w_eff_phase = r_phase;
        w_eff_ticks = r_ticks;
        w_eff_err   = r_err;
        if (r_phase == PH_IDLE && i_cmd) begin
            w_eff_phase = PH_TLOW;
            w_eff_ticks = '0;
            w_eff_err   = 1'b0;
        end
        n_phase = w_eff_phase;
        n_ticks = w_eff_ticks;
        n_err   = w_eff_err;
        case (w_eff_phase)
            PH_TLOW: begin
                n_ticks = w_eff_ticks + TICK_W'(1);
                if (n_ticks >= TICK_W'(TRIG_LOW_TICKS)) begin
                    n_phase = PH_THIGH;
                    n_ticks = '0;
                end
            end
            PH_THIGH: begin
                n_ticks = w_eff_ticks + TICK_W'(1);
                if (n_ticks >= TICK_W'(TRIG_HIGH_TICKS)) begin
                    n_phase = PH_WAIT;
                    n_ticks = '0;
                end
            end
            PH_WAIT: begin
                if (i_echo) begin
                    n_phase = PH_MEAS;
                    n_ticks = TICK_W'(1);
                end else if (w_eff_ticks >= i_timeout) begin
                    n_phase = PH_IDLE;
                    n_ticks = '0;
                    n_err   = 1'b1;
                end else begin
                    n_ticks = w_eff_ticks + TICK_W'(1);
                end
            end
            PH_MEAS: begin
                if (!i_echo) begin
                    n_phase = PH_IDLE;
                    n_ticks = '0;
                end else if (w_eff_ticks >= i_timeout) begin
                    n_phase = PH_IDLE;
                    n_ticks = '0;
                    n_err   = 1'b1;
                end else begin
                    n_ticks = w_eff_ticks + TICK_W'(1);
                end
            end
            default: begin
                n_phase = w_eff_phase;
            end
        endcase
    end

    // Outputs of this tick
    always_comb begin
        w_to_err = i_echo ? (w_eff_phase == PH_MEAS) : (w_eff_phase == PH_WAIT);
        w_to_err = w_to_err && (w_eff_ticks >= i_timeout);
        w_done   = w_to_err || (w_eff_phase == PH_MEAS && !i_echo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ticks <= '0;
            r_err   <= 1'b0;
            r_pre   <= '0;
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_accept;
            if (i_accept) begin
                r_phase <= n_phase;
                r_ticks <= n_ticks;
                r_err   <= n_err;
                r_pre   <= n_pre;
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_adv && i_accept) begin
            r_flags.trig  <= (w_eff_phase == PH_THIGH);
            r_flags.busy  <= (n_phase != PH_IDLE);
            r_flags.done  <= w_done;
            r_flags.error <= n_err;
            r_flags.succ  <= w_done && !w_to_err;
            r_flags.wrap  <= w_wrap;
            r_out_ticks   <= w_eff_ticks;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_ticks = r_out_ticks;

endmodule

### rtl/urgl_scale.sv
module urgl_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  urgl_pkg::t_flags            i_flags,
    input  logic [urgl_pkg::TICK_W-1:0] i_ticks,
    output logic                        o_valid,
    output urgl_pkg::t_flags            o_flags,
    output logic [urgl_pkg::DIST_W-1:0] o_dist
);
    import urgl_pkg::*;

    logic               r_v2, r_v3;
    t_flags             r_f2, r_f3;
    logic [SCALE_W-1:0] r_num, n_num;
    logic [DIST_W-1:0]  r_dist, n_dist;
    logic [PROD_W-1:0]  w_prod;

    // Numerator: us*343 + 625
    always_comb begin
        n_num = SCALE_W'(i_ticks) * SCALE_MUL + SCALE_ADD;
    end

    // Reciprocal multiply, quotient taken from the top bits
    always_comb begin
        w_prod = PROD_W'(r_num) * PROD_W'(RECIP);
        n_dist = w_prod[RECIP_SHIFT +: DIST_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_f2   <= i_flags;
            r_num  <= n_num;
            r_f3   <= r_f2;
            r_dist <= n_dist;
        end
    end

    assign o_valid = r_v3;
    assign o_flags = r_f3;
    assign o_dist  = r_dist;

endmodule

### rtl/urgl_judge.sv
module urgl_judge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  urgl_pkg::t_flags            i_flags,
    input  logic [urgl_pkg::DIST_W-1:0] i_dist,
    input  logic [urgl_pkg::THR_W-1:0]  i_threshold,
    input  logic [urgl_pkg::HYS_W-1:0]  i_hysteresis,
    input  logic [urgl_pkg::MS_W-1:0]   i_cooldown,
    output logic                        o_valid,
    output urgl_pkg::t_flags            o_flags,
    output logic [urgl_pkg::DIST_W-1:0] o_dist,
    output logic                        o_gesture
);
    import urgl_pkg::*;

    logic [MS_W-1:0]   r_ms, n_ms, w_ms_inc;
    logic              r_latched, n_latched;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic              n_gest;
    logic [THR_W:0]    w_release;

    logic              r_valid;
    t_flags            r_flags;
    logic              r_gest;

    // Millisecond count, saturating
    always_comb begin
        w_ms_inc = r_ms;
        if (i_flags.wrap && r_ms != '1) begin
            w_ms_inc = r_ms + MS_W'(1);
        end
    end

    // Distance update and latched gesture decision
    always_comb begin
        w_release = (THR_W+1)'(i_threshold) + (THR_W+1)'(i_hysteresis);
        n_ms      = w_ms_inc;
        n_latched = r_latched;
        n_dist    = r_dist;
        n_gest    = 1'b0;
        if (i_flags.succ) begin
            n_dist = i_dist;
            if (r_latched) begin
                if (DIST_W'(i_dist) >= DIST_W'(w_release)) begin
                    n_latched = 1'b0;
                end
            end else if (i_dist <= DIST_W'(i_threshold) && w_ms_inc >= i_cooldown) begin
                n_latched = 1'b1;
                n_ms      = '0;
                n_gest    = 1'b1;
            end
        end else if (i_flags.done && i_flags.error) begin
            n_dist = DIST_ERR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms      <= '0;
            r_latched <= 1'b0;
            r_dist    <= DIST_ERR;
            r_valid   <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_ms      <= n_ms;
                r_latched <= n_latched;
                r_dist    <= n_dist;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_flags <= i_flags;
            r_gest  <= n_gest;
        end
    end

    assign o_valid   = r_valid;
    assign o_flags   = r_flags;
    assign o_dist    = r_dist;
    assign o_gesture = r_gest;

endmodule
